@@ design/tpwd_pkg.sv @@
// -----------------------------------------------------------------------------
// tpwd_pkg
// Shared types and constants for the tape pulse width decoder.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpwd_pkg;

  // Field widths
  localparam int unsigned DeltaW   = 20;
  localparam int unsigned ThreshW  = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned BitIdxW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPilot   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStart   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegOne     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegTimeout = 2'd3;

  // Configuration reset values
  localparam logic [ThreshW-1:0] PilotRst   = 32'd1116000;
  localparam logic [ThreshW-1:0] StartRst   = 32'd334800;
  localparam logic [ThreshW-1:0] OneRst     = 32'd750000;
  localparam logic [ThreshW-1:0] TimeoutRst = 32'd2480000;

  // Result kinds
  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // Threshold set
  typedef struct packed {
    logic [ThreshW-1:0] pilot_threshold_ns;
    logic [ThreshW-1:0] start_threshold_ns;
    logic [ThreshW-1:0] one_threshold_ns;
    logic [ThreshW-1:0] timeout_ns;
  } cfg_t;

  // One tick held in the input register
  typedef struct packed {
    logic              valid;
    logic [DeltaW-1:0] delta_ns;
    logic              ear_level;
  } tick_t;

  // Result of one tick
  typedef struct packed {
    logic               valid;
    logic               result_kind;
    logic [ByteW-1:0]   data_byte;
    logic [CountW-1:0]  block_length;
    logic [BitIdxW-1:0] dropped_bits;
  } res_t;

endpackage

@@ design/tpwd_cfg_regs.sv @@
// -----------------------------------------------------------------------------
// tpwd_cfg_regs
// Threshold registers written through the plain configuration write port.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpwd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tpwd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tpwd_pkg::ThreshW-1:0]   cfg_wdata_i,
  output tpwd_pkg::cfg_t                 cfg_o
);

  tpwd_pkg::cfg_t cfg_q;

  // Register writes, one register per index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pilot_threshold_ns <= tpwd_pkg::PilotRst;
      cfg_q.start_threshold_ns <= tpwd_pkg::StartRst;
      cfg_q.one_threshold_ns   <= tpwd_pkg::OneRst;
      cfg_q.timeout_ns         <= tpwd_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tpwd_pkg::RegPilot:   cfg_q.pilot_threshold_ns <= cfg_wdata_i;
        tpwd_pkg::RegStart:   cfg_q.start_threshold_ns <= cfg_wdata_i;
        tpwd_pkg::RegOne:     cfg_q.one_threshold_ns   <= cfg_wdata_i;
        tpwd_pkg::RegTimeout: cfg_q.timeout_ns         <= cfg_wdata_i;
        default:              cfg_q                    <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/tpwd_in_reg.sv @@
// -----------------------------------------------------------------------------
// tpwd_in_reg
// Input register stage: captures one tick per transfer, holds it while the
// result side stalls.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpwd_in_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tpwd_pkg::DeltaW-1:0]   delta_ns_i,
  input  logic                          ear_level_i,
  input  logic                          advance_i,
  output tpwd_pkg::tick_t               tick_o
);

  logic                        vld_q;
  logic [tpwd_pkg::DeltaW-1:0] delta_q;
  logic                        level_q;

  // Free when empty or when the held tick moves on this cycle
  assign in_ready_o = !vld_q || advance_i;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      delta_q <= delta_ns_i;
      level_q <= ear_level_i;
    end
  end

  assign tick_o.valid     = vld_q;
  assign tick_o.delta_ns  = delta_q;
  assign tick_o.ear_level = level_q;

endmodule

@@ design/tpwd_decoder.sv @@
// -----------------------------------------------------------------------------
// tpwd_decoder
// Period timer, phase machine and bit packer. Computes the result of the held
// tick and commits the new state when the tick moves on.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpwd_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tpwd_pkg::tick_t tick_i,
  input  logic            commit_i,
  input  tpwd_pkg::cfg_t  cfg_i,
  output tpwd_pkg::res_t  res_o
);

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhPilot = 2'd1,
    PhData  = 2'd2
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [tpwd_pkg::ThreshW-1:0]    elapsed_q, elapsed_d;
  logic [tpwd_pkg::BitIdxW-1:0]    bit_idx_q, bit_idx_d;
  logic [tpwd_pkg::ByteW-1:0]      partial_q, partial_d;
  logic [tpwd_pkg::CountW-1:0]     count_q, count_d;
  logic                            prev_q, prev_d;

  logic [tpwd_pkg::ThreshW:0]      sum;
  logic [tpwd_pkg::ThreshW-1:0]    elapsed_sat;
  logic                            rise;
  logic                            is_long, is_start, is_one, is_timeout;
  logic [tpwd_pkg::ByteW-1:0]      bit_mask;
  logic [tpwd_pkg::ByteW-1:0]      byte_new;
  tpwd_pkg::res_t                  res;

  // Saturating timer add and threshold compares
  assign sum         = {1'b0, elapsed_q} + {{(tpwd_pkg::ThreshW + 1 - tpwd_pkg::DeltaW){1'b0}},
                                            tick_i.delta_ns};
  assign elapsed_sat = sum[tpwd_pkg::ThreshW] ? '1 : sum[tpwd_pkg::ThreshW-1:0];
  assign rise        = tick_i.ear_level && !prev_q;
  assign is_long     = elapsed_sat > cfg_i.pilot_threshold_ns;
  assign is_start    = elapsed_sat > cfg_i.start_threshold_ns;
  assign is_one      = elapsed_sat > cfg_i.one_threshold_ns;
  assign is_timeout  = elapsed_sat > cfg_i.timeout_ns;

  // MSB-first bit placement
  assign bit_mask = 8'h80 >> bit_idx_q;
  assign byte_new = is_one ? (partial_q | bit_mask) : partial_q;

  // Next state and result
  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_sat;
    bit_idx_d = bit_idx_q;
    partial_d = partial_q;
    count_d   = count_q;
    prev_d    = tick_i.ear_level;
    res       = '0;

    if (rise) begin
      elapsed_d = '0;
      if (is_long) begin
        unique case (phase_q)
          PhIdle:  phase_d = PhPilot;
          PhData: begin
            res.valid        = 1'b1;
            res.result_kind  = tpwd_pkg::KindEnd;
            res.block_length = count_q;
            res.dropped_bits = bit_idx_q;
            bit_idx_d        = '0;
            partial_d        = '0;
            phase_d          = PhIdle;
          end
          default: phase_d = phase_q;
        endcase
      end else if (phase_q == PhPilot) begin
        if (is_start) begin
          phase_d   = PhData;
          count_d   = '0;
          bit_idx_d = '0;
          partial_d = '0;
        end
      end else if (phase_q == PhData) begin
        bit_idx_d = bit_idx_q + 1'b1;
        partial_d = byte_new;
        // Byte complete
        if (bit_idx_q == '1) begin
          res.valid       = 1'b1;
          res.result_kind = tpwd_pkg::KindData;
          res.data_byte   = byte_new;
          partial_d       = '0;
          count_d         = count_q + 1'b1;
        end
      end
    end else if (phase_q == PhData && is_timeout) begin
      // Silence ends the block
      res.valid        = 1'b1;
      res.result_kind  = tpwd_pkg::KindEnd;
      res.block_length = count_q;
      res.dropped_bits = bit_idx_q;
      bit_idx_d        = '0;
      partial_d        = '0;
      phase_d          = PhIdle;
    end
  end

  // State commit on each tick that moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      elapsed_q <= '0;
      bit_idx_q <= '0;
      partial_q <= '0;
      count_q   <= '0;
      prev_q    <= 1'b0;
    end else if (commit_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      bit_idx_q <= bit_idx_d;
      partial_q <= partial_d;
      count_q   <= count_d;
      prev_q    <= prev_d;
    end
  end

  assign res_o = res;

  // A byte result always closes a full byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.result_kind == tpwd_pkg::KindData |-> bit_idx_d == '0)
    else $error("byte emitted with bits left over");

  // Leaving data clears the packer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && phase_q == PhData && phase_d == PhIdle |=> bit_idx_q == '0 && partial_q == '0)
    else $error("packer not cleared at block end");

  // The timer restarts at every committed rising edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && rise |=> elapsed_q == '0)
    else $error("timer not restarted on rising edge");

endmodule

@@ design/tape_pulse_width_decoder_core.sv @@
// -----------------------------------------------------------------------------
// tape_pulse_width_decoder_core
// Tape pulse width decoder: turns sampled tape ticks into data bytes and
// end-of-block reports.
// -----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick per transfer: tdata[19:0] elapsed ns since the
//   previous tick, tdata[20] sampled tape level. m_axis carries results:
//   tuser[0] is the kind (0 data byte, 1 end of block), tdata holds the byte,
//   the block length and the dropped bit count. A tick yields zero or one
//   result.
//   Thresholds are written through cfg_we_i / cfg_index_i / cfg_wdata_i while
//   the block is idle; they take effect on the next tick.
//   A tick is captured in the input register and its result in the result
//   register; the decoder between them is combinational. Throughput: one
//   tick per cycle while the result side does not stall; the timer add and the
//   four threshold compares fit between the two registers.
//   When m_axis_tready is low with a result held, one further tick is held in
//   the input register and s_axis_tready drops until the result is taken.
//   Reset restores the default thresholds, returns to idle with the timer,
//   byte count and bit packer cleared, and empties both registers.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tape_pulse_width_decoder_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Tick stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tpwd_pkg::InDataW-1:0]     s_axis_tdata,  // delta_ns[19:0], ear_level[20]
  // Result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tpwd_pkg::OutDataW-1:0]    m_axis_tdata,  // data_byte[7:0], block_length[23:8],
                                                          // dropped_bits[26:24]
  output logic                             m_axis_tuser,  // result_kind[0]
  // Configuration
  input  logic                             cfg_we_i,
  input  logic [tpwd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tpwd_pkg::ThreshW-1:0]     cfg_wdata_i
);

  tpwd_pkg::cfg_t  cfg;
  tpwd_pkg::tick_t tick;
  tpwd_pkg::res_t  res;
  logic            advance;
  logic            commit;

  logic                            out_vld_q;
  logic                            kind_q;
  logic [tpwd_pkg::ByteW-1:0]      byte_q;
  logic [tpwd_pkg::CountW-1:0]     len_q;
  logic [tpwd_pkg::BitIdxW-1:0]    drop_q;

  tpwd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tpwd_in_reg u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .delta_ns_i  (s_axis_tdata[tpwd_pkg::DeltaW-1:0]),
    .ear_level_i (s_axis_tdata[tpwd_pkg::DeltaW]),
    .advance_i   (advance),
    .tick_o      (tick)
  );

  // Held tick moves on when the result register is free or being drained
  assign advance = !out_vld_q || m_axis_tready;
  assign commit  = tick.valid && advance;

  tpwd_decoder u_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .commit_i (commit),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= commit && res.valid;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (commit && res.valid) begin
      kind_q <= res.result_kind;
      byte_q <= res.data_byte;
      len_q  <= res.block_length;
      drop_q <= res.dropped_bits;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {5'd0, drop_q, len_q, byte_q};

  // Input side only stalls behind a held, untaken result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // Byte results carry no length or dropped count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == tpwd_pkg::KindData |-> m_axis_tdata[26:8] == '0)
    else $error("byte result with block fields set");

  // End-of-block results carry no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == tpwd_pkg::KindEnd |-> m_axis_tdata[7:0] == '0)
    else $error("end-of-block result with byte set");

endmodule

@@ sim/tb_tape_pulse_width_decoder_core.sv @@
// -----------------------------------------------------------------------------
// tb_tape_pulse_width_decoder_core
// Self-checking bench for the tape pulse width decoder. Ticks are streamed in
// with random gaps and a randomly stalling result sink. Every accepted tick
// runs through a local model of the decoder, and each result transfer is
// compared in order against the decoded bytes and block ends that the model
// predicts. Directed cases cover the reset thresholds, timeout and edge
// priority, and long silences. Random rounds of pilot / start / bit / end
// sequences then run under several threshold sets, the extremes included.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tape_pulse_width_decoder_core;

  localparam int unsigned DeltaMax      = (1 << tpwd_pkg::DeltaW) - 1;
  localparam int unsigned PeriodCap     = 3 * DeltaMax;
  localparam int unsigned ResultBits    = tpwd_pkg::ByteW + tpwd_pkg::CountW +
                                          tpwd_pkg::BitIdxW;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ReportLimit   = 10;

  typedef enum logic [1:0] {
    PhaseIdle  = 2'd0,
    PhasePilot = 2'd1,
    PhaseData  = 2'd2
  } tape_phase_e;

  // One decoded result as it appears on the result stream
  typedef struct packed {
    logic                         kind;
    logic [tpwd_pkg::BitIdxW-1:0] dropped_bits;
    logic [tpwd_pkg::CountW-1:0]  block_length;
    logic [tpwd_pkg::ByteW-1:0]   data_byte;
  } decode_t;

  logic                          clk_i;
  logic                          rst_ni         = 1'b0;
  logic                          s_axis_tvalid  = 1'b0;
  logic                          s_axis_tready;
  logic [tpwd_pkg::InDataW-1:0]  s_axis_tdata   = '0;   // delta_ns[19:0], ear_level[20]
  logic                          m_axis_tvalid;
  logic                          m_axis_tready  = 1'b0;
  logic [tpwd_pkg::OutDataW-1:0] m_axis_tdata;          // data_byte[7:0],
                                                        // block_length[23:8],
                                                        // dropped_bits[26:24]
  logic                          m_axis_tuser;          // result_kind[0]
  logic                          cfg_we_i       = 1'b0;
  logic [tpwd_pkg::CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [tpwd_pkg::ThreshW-1:0]  cfg_wdata_i    = '0;

  tape_pulse_width_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Decoder model state
  tpwd_pkg::cfg_t               thresholds = '{tpwd_pkg::PilotRst, tpwd_pkg::StartRst,
                                               tpwd_pkg::OneRst, tpwd_pkg::TimeoutRst};
  tape_phase_e                  tape_phase     = PhaseIdle;
  logic [tpwd_pkg::ThreshW-1:0] timer_ns       = '0;
  logic [tpwd_pkg::BitIdxW-1:0] bit_pos        = '0;
  logic [tpwd_pkg::ByteW-1:0]   shift_byte     = '0;
  logic [tpwd_pkg::CountW-1:0]  bytes_in_block = '0;
  logic                         last_level     = 1'b0;

  decode_t     decodes_due[$];
  int unsigned mismatches     = 0;
  int unsigned tick_count     = 0;
  int unsigned stalled_cycles = 0;
  logic        gaps_on        = 1'b1;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // Block end: report count and partial bits, back to idle
  task automatic close_block();
    decodes_due.push_back('{tpwd_pkg::KindEnd, bit_pos, bytes_in_block, '0});
    bit_pos    = '0;
    shift_byte = '0;
    tape_phase = PhaseIdle;
  endtask

  // Advance the model by one accepted tick
  task automatic decode_tick(input logic [tpwd_pkg::DeltaW-1:0] delta, input logic level);
    logic [tpwd_pkg::ThreshW:0]   sum;
    logic [tpwd_pkg::ThreshW-1:0] period;
    sum      = {1'b0, timer_ns} +
               {{(tpwd_pkg::ThreshW + 1 - tpwd_pkg::DeltaW){1'b0}}, delta};
    timer_ns = sum[tpwd_pkg::ThreshW] ? '1 : sum[tpwd_pkg::ThreshW-1:0];
    if (level && !last_level) begin
      period   = timer_ns;
      timer_ns = '0;
      if (period > thresholds.pilot_threshold_ns) begin
        if (tape_phase == PhaseIdle) tape_phase = PhasePilot;
        else if (tape_phase == PhaseData) close_block();
      end else if (tape_phase == PhasePilot) begin
        if (period > thresholds.start_threshold_ns) begin
          tape_phase     = PhaseData;
          bytes_in_block = '0;
          bit_pos        = '0;
          shift_byte     = '0;
        end
      end else if (tape_phase == PhaseData) begin
        // MSB first
        if (period > thresholds.one_threshold_ns) shift_byte[3'd7 - bit_pos] = 1'b1;
        if (bit_pos == 3'd7) begin
          decodes_due.push_back('{tpwd_pkg::KindData, '0, '0, shift_byte});
          bit_pos        = '0;
          shift_byte     = '0;
          bytes_in_block = bytes_in_block + 1'b1;
        end else begin
          bit_pos = bit_pos + 1'b1;
        end
      end
    end else if (tape_phase == PhaseData && timer_ns > thresholds.timeout_ns) begin
      close_block();
    end
    last_level = level;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One tick transfer, with an optional gap in front
  task automatic send_tick(input logic [tpwd_pkg::DeltaW-1:0] delta, input logic level);
    @(negedge clk_i);
    if (gaps_on && $urandom_range(99, 0) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(tpwd_pkg::InDataW - tpwd_pkg::DeltaW - 1){1'b0}}, level, delta};
    do @(posedge clk_i); while (!s_axis_tready);
    decode_tick(delta, level);
    tick_count++;
  endtask

  // Low ticks followed by a high tick, so that the rising edge sees this period
  task automatic send_edge(input int unsigned period);
    int unsigned rem;
    int unsigned d;
    rem = period;
    if (rem <= DeltaMax) begin
      d = $urandom_range(rem, 0);
      send_tick(d[tpwd_pkg::DeltaW-1:0], 1'b0);
      rem -= d;
    end
    while (rem > DeltaMax) begin
      send_tick(DeltaMax[tpwd_pkg::DeltaW-1:0], 1'b0);
      rem -= DeltaMax;
    end
    send_tick(rem[tpwd_pkg::DeltaW-1:0], 1'b1);
  endtask

  // Raw ticks with random delta and level
  task automatic send_noise();
    int unsigned d;
    int unsigned lvl;
    repeat ($urandom_range(6, 1)) begin
      d   = $urandom_range(1, 0) ? $urandom() : $urandom_range(5000, 0);
      lvl = $urandom_range(1, 0);
      send_tick(d[tpwd_pkg::DeltaW-1:0], lvl[0]);
    end
  endtask

  // Stop sending and let every predicted result drain out
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (decodes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tpwd_pkg::CfgIdxW-1:0] idx,
                           input logic [tpwd_pkg::ThreshW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      tpwd_pkg::RegPilot:   thresholds.pilot_threshold_ns = val;
      tpwd_pkg::RegStart:   thresholds.start_threshold_ns = val;
      tpwd_pkg::RegOne:     thresholds.one_threshold_ns   = val;
      tpwd_pkg::RegTimeout: thresholds.timeout_ns         = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [tpwd_pkg::ThreshW-1:0] pilot,
                                input logic [tpwd_pkg::ThreshW-1:0] start,
                                input logic [tpwd_pkg::ThreshW-1:0] one,
                                input logic [tpwd_pkg::ThreshW-1:0] tmo);
    write_reg(tpwd_pkg::RegPilot, pilot);
    write_reg(tpwd_pkg::RegStart, start);
    write_reg(tpwd_pkg::RegOne, one);
    write_reg(tpwd_pkg::RegTimeout, tmo);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Period generators, capped so a period never needs more than a few ticks
  function automatic int unsigned pick_above(input int unsigned thr);
    int unsigned hi;
    if (thr >= PeriodCap) return PeriodCap;
    hi = thr + 1 + thr / 4 + 1000;
    return $urandom_range((hi > PeriodCap) ? PeriodCap : hi, thr + 1);
  endfunction

  function automatic int unsigned pick_between(input int unsigned lo, input int unsigned hi);
    int unsigned lo_c, hi_c;
    lo_c = (lo >= PeriodCap) ? PeriodCap : lo + 1;
    hi_c = (hi > PeriodCap) ? PeriodCap : hi;
    if (hi_c < lo_c) return hi_c;
    return $urandom_range(hi_c, lo_c);
  endfunction

  function automatic int unsigned pick_at_most(input int unsigned hi);
    return $urandom_range((hi > PeriodCap) ? PeriodCap : hi, 0);
  endfunction

  task automatic pick_thresholds(output logic [tpwd_pkg::ThreshW-1:0] p,
                                 output logic [tpwd_pkg::ThreshW-1:0] s,
                                 output logic [tpwd_pkg::ThreshW-1:0] o,
                                 output logic [tpwd_pkg::ThreshW-1:0] t);
    p = $urandom_range(1_500_000, 200_000);
    s = $urandom_range(p - 1, p / 8);
    o = $urandom_range(p - 1, p / 4);
    // mostly a timeout past the pilot period, sometimes one that cuts bits short
    t = ($urandom_range(99, 0) < 20) ? $urandom_range(p, o)
                                     : p + $urandom_range(2_000_000, 50_000);
  endtask

  // Pilot, start, a run of bits, then an end by long pulse, silence or noise
  task automatic send_block();
    int unsigned nbits;
    int unsigned rem;
    int unsigned d;
    repeat ($urandom_range(3, 1)) send_edge(pick_above(thresholds.pilot_threshold_ns));
    if ($urandom_range(99, 0) < 15) send_edge(pick_at_most(thresholds.start_threshold_ns));
    if ($urandom_range(99, 0) < 90)
      send_edge(pick_between(thresholds.start_threshold_ns, thresholds.pilot_threshold_ns));
    nbits = ($urandom_range(99, 0) < 30) ? 8 * $urandom_range(4, 1) : $urandom_range(40, 0);
    repeat (nbits) begin
      if ($urandom_range(1, 0))
        send_edge(pick_between(thresholds.one_threshold_ns, thresholds.pilot_threshold_ns));
      else
        send_edge(pick_at_most((thresholds.one_threshold_ns < thresholds.pilot_threshold_ns) ?
                               thresholds.one_threshold_ns : thresholds.pilot_threshold_ns));
    end
    case ($urandom_range(2, 0))
      0: send_edge(pick_above(thresholds.pilot_threshold_ns));
      1: begin
        // silence past the timeout
        rem = pick_above(thresholds.timeout_ns);
        while (rem > 0) begin
          d = (rem > DeltaMax) ? DeltaMax : rem;
          send_tick(d[tpwd_pkg::DeltaW-1:0], 1'b0);
          rem -= d;
        end
      end
      default: send_noise();
    endcase
  endtask

  task automatic run_round(input int unsigned budget,
                           input logic [tpwd_pkg::ThreshW-1:0] p,
                           input logic [tpwd_pkg::ThreshW-1:0] s,
                           input logic [tpwd_pkg::ThreshW-1:0] o,
                           input logic [tpwd_pkg::ThreshW-1:0] t);
    int unsigned first_tick;
    wait_idle();
    set_thresholds(p, s, o, t);
    first_tick = tick_count;
    while (tick_count - first_tick < budget) begin
      if ($urandom_range(99, 0) < 80) send_block();
      else send_noise();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset thresholds, no register written yet
  task automatic test_reset_thresholds();
    send_edge(1000);         // short period in idle: ignored
    send_edge(1_116_001);    // pilot
    send_edge(1_200_000);    // long period in pilot: ignored
    send_edge(334_800);      // at the start threshold: ignored
    send_edge(334_801);      // data
    send_edge(750_001);      // 1
    send_edge(750_000);      // 0
    send_edge(1_116_001);    // long pulse ends block, two bits dropped
  endtask

  // Timeout end and edge priority over the timeout
  task automatic test_timeout_priority();
    wait_idle();
    set_thresholds(32'd10_000, 32'd4_000, 32'd2_000, 32'd8_000);
    send_tick(DeltaMax[tpwd_pkg::DeltaW-1:0], 1'b0);
    send_tick('0, 1'b1);     // pilot
    send_edge(3_000);        // not above start: ignored
    send_edge(5_000);        // data
    send_edge(3_000);
    send_edge(1_000);
    send_tick('0, 1'b0);
    send_tick(20'd9_000, 1'b1);  // past timeout, but the edge wins: a 1 bit
    send_tick(20'd8_001, 1'b0);  // silence: block ends, three bits dropped
  endtask

  // Long silences in idle and in data, timer far above any bit period
  task automatic test_long_silence();
    wait_idle();
    set_thresholds(32'd200_000_000, '0, '0, '1);
    repeat (200) send_tick(DeltaMax[tpwd_pkg::DeltaW-1:0], 1'b0);
    send_tick('0, 1'b1);     // long period: pilot
    send_edge(1);            // data
    repeat (11) send_edge(1);
    repeat (200) send_tick(DeltaMax[tpwd_pkg::DeltaW-1:0], 1'b0);
    send_tick('0, 1'b1);     // long pulse: one byte, three bits dropped
  endtask

  task automatic test_random_traffic();
    logic [tpwd_pkg::ThreshW-1:0] p, s, o, t;
    run_round(50, '0, '0, '0, '0);
    run_round(50, '1, '1, '1, '1);
    run_round(50, tpwd_pkg::PilotRst, tpwd_pkg::StartRst, tpwd_pkg::OneRst,
              tpwd_pkg::TimeoutRst);
    pick_thresholds(p, s, o, t);
    run_round(50, p, s, o, '0);
    for (int r = 0; r < 4; r++) begin
      pick_thresholds(p, s, o, t);
      gaps_on = (r != 1);
      run_round(260, p, s, o, t);
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_thresholds();
    test_timeout_priority();
    test_long_silence();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0 && decodes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result sink with random stalls while gaps are on
  always @(negedge clk_i) begin
    m_axis_tready <= gaps_on ? ($urandom_range(99, 0) >= 15) : 1'b1;
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : result_check
    decode_t want;
    decode_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[ResultBits-1:0]};
      if (decodes_due.size() == 0) begin
        if (mismatches < ReportLimit)
          $display("unexpected result: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = decodes_due.pop_front();
        if (got !== want || m_axis_tdata[tpwd_pkg::OutDataW-1:ResultBits] !== '0) begin
          if (mismatches < ReportLimit)
            $display("mismatch: want kind %0d byte %h len %0d drop %0d, got kind %0d tdata %h",
                     want.kind, want.data_byte, want.block_length, want.dropped_bits,
                     m_axis_tuser, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WatchdogLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

endmodule
